// File: hw/rtl/brbe_pkg.sv
// brbe_pkg: shared types, widths and codes for the byte ring buffer engine.
// Used by brbe_mod, brbe_ram, byte_ring_buffer_engine and brbe_chk; no dependencies.
package brbe_pkg;

  localparam int MaxCap   = 1024;
  localparam int AddrW    = $clog2(MaxCap);
  localparam int CntW     = AddrW + 1;
  localparam int DvdW     = CntW + 1;
  localparam int StepW    = $clog2(DvdW + 1);
  localparam int WordW    = 32;
  localparam int ByteW    = 8;
  localparam int PushCntW = 3;
  localparam int PushMax  = 4;

  typedef enum logic [2:0] {
    ACT_PUSH   = 3'd0,
    ACT_READ   = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_CLEAR  = 3'd3,
    ACT_PREFIX = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_BAD      = 3'd1,
    STS_EMPTY    = 3'd2,
    STS_OVERFLOW = 3'd3,
    STS_NOMATCH  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_PHYS,
    FSM_SRC,
    FSM_PUSH,
    FSM_READ,
    FSM_MV_RD,
    FSM_MV_WR,
    FSM_DONE
  } fsm_e;

  typedef struct packed {
    logic            start;
    logic [DvdW-1:0] dividend;
    logic [CntW-1:0] divisor;
  } mod_req_t;

endpackage

// File: hw/rtl/brbe_ram.sv
// brbe_ram: single-port byte store with a synchronous, registered read.
// Depends on brbe_pkg for its depth and widths.
module brbe_ram (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic                          re_i,
  input  logic [brbe_pkg::AddrW-1:0]    addr_i,
  input  logic [brbe_pkg::ByteW-1:0]    wdata_i,
  output logic [brbe_pkg::ByteW-1:0]    rdata_o
);

  logic [brbe_pkg::ByteW-1:0] mem [brbe_pkg::MaxCap];
  logic [brbe_pkg::ByteW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/brbe_mod.sv
// brbe_mod: restoring remainder unit, one dividend bit per cycle.
// Depends on brbe_pkg for widths and the request struct.
module brbe_mod (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  brbe_pkg::mod_req_t         req_i,
  output logic                       done_o,
  output logic [brbe_pkg::AddrW-1:0] result_o
);

  logic [brbe_pkg::StepW-1:0] step_q, step_d;
  logic                       done_q, done_d;
  logic [brbe_pkg::DvdW-1:0]  dvd_q, dvd_d;
  logic [brbe_pkg::CntW-1:0]  div_q, div_d;
  logic [brbe_pkg::CntW-1:0]  rem_q, rem_d;
  logic [brbe_pkg::DvdW-1:0]  trial;

  always_comb begin
    trial  = {rem_q, dvd_q[brbe_pkg::DvdW-1]};
    step_d = step_q;
    done_d = 1'b0;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      step_d = brbe_pkg::StepW'(brbe_pkg::DvdW);
      dvd_d  = req_i.dividend;
      div_d  = req_i.divisor;
      rem_d  = '0;
    end else if (step_q != '0) begin
      // shift in the next bit, subtract when it fits
      if (trial >= {1'b0, div_q}) begin
        rem_d = brbe_pkg::CntW'(trial - {1'b0, div_q});
      end else begin
        rem_d = brbe_pkg::CntW'(trial);
      end
      dvd_d  = {dvd_q[brbe_pkg::DvdW-2:0], 1'b0};
      step_d = step_q - 1'b1;
      done_d = (step_q == brbe_pkg::StepW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o   = done_q;
  assign result_o = rem_q[brbe_pkg::AddrW-1:0];

endmodule

// File: hw/rtl/byte_ring_buffer_engine.sv
// byte_ring_buffer_engine: top level of the circular byte store with prefix check.
// Depends on brbe_pkg, brbe_ram and brbe_mod.
// Sequence: an item that needs no store access (errors, clear, tail truncation,
//   full clear) goes from IDLE to DONE; one that maps a logical index runs the
//   remainder unit first (PHYS): a read or prefix byte then passes READ, a push writes
//   its bytes in PUSH, a middle removal maps its source (SRC) and loops MV_RD, MV_WR.
// Throughput: one item at a time; the single-port store and the remainder unit set it.
// Reset: head, fill, prefix state cleared and capacity set to 1024; store contents undefined.
module byte_ring_buffer_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel (buffer_capacity)
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [brbe_pkg::CntW-1:0]     cfg_data_i,
  // item channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    action_i,
  input  logic [brbe_pkg::WordW-1:0]    push_word_i,
  input  logic [brbe_pkg::PushCntW-1:0] push_count_i,
  input  logic [brbe_pkg::AddrW-1:0]    position_i,
  input  logic [brbe_pkg::CntW-1:0]     remove_size_i,
  input  logic [brbe_pkg::ByteW-1:0]    prefix_value_i,
  input  logic                          prefix_last_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    status_o,
  output logic [brbe_pkg::ByteW-1:0]    read_byte_o,
  output logic [brbe_pkg::CntW-1:0]     fill_level_o
);

  localparam int AW = brbe_pkg::AddrW;
  localparam int CW = brbe_pkg::CntW;
  localparam int DW = brbe_pkg::DvdW;

  brbe_pkg::fsm_e state_q, state_d;

  // control state
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] ppos_q, ppos_d;
  logic          pfail_q, pfail_d;
  logic [CW-1:0] cap_q, cap_d;
  logic          out_valid_q, out_valid_d;

  // latched transaction and work registers
  logic [2:0]                    act_q, act_d;
  logic [brbe_pkg::WordW-1:0]    word_q, word_d;
  logic [brbe_pkg::PushCntW-1:0] pcnt_q, pcnt_d;
  logic [AW-1:0]                 pos_q, pos_d;
  logic [CW-1:0]                 size_q, size_d;
  logic [brbe_pkg::ByteW-1:0]    pval_q, pval_d;
  logic                          plast_q, plast_d;
  logic [AW-1:0]                 ptr_q, ptr_d;
  logic [AW-1:0]                 src_q, src_d;
  logic [CW-1:0]                 left_q, left_d;
  logic [1:0]                    k_q, k_d;
  logic [2:0]                    res_sts_q, res_sts_d;
  logic [brbe_pkg::ByteW-1:0]    res_byte_q, res_byte_d;
  logic [2:0]                    out_sts_q, out_sts_d;
  logic [brbe_pkg::ByteW-1:0]    out_byte_q, out_byte_d;
  logic [CW-1:0]                 out_fill_q, out_fill_d;

  // effective capacity: zero acts as one, above the maximum clamps
  logic [CW-1:0] eff_cap;
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CW'(1);
    end else if (cap_q > CW'(brbe_pkg::MaxCap)) begin
      eff_cap = CW'(brbe_pkg::MaxCap);
    end else begin
      eff_cap = cap_q;
    end
  end

  function automatic logic [AW-1:0] ring_inc(logic [AW-1:0] p, logic [CW-1:0] cap);
    logic [CW-1:0] nxt;
    nxt = {1'b0, p} + CW'(1);
    return (nxt == cap) ? '0 : nxt[AW-1:0];
  endfunction

  // remainder unit and store
  brbe_pkg::mod_req_t      mod_req;
  logic                    mod_done;
  logic [AW-1:0]           mod_res;
  logic                    mem_we, mem_re;
  logic [AW-1:0]           mem_addr;
  logic [brbe_pkg::ByteW-1:0] mem_wdata, mem_rdata;

  brbe_mod u_mod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mod_req),
    .done_o   (mod_done),
    .result_o (mod_res)
  );

  brbe_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // decode of an incoming transaction: immediate status and whether a
  // logical index must be mapped to a slot first
  logic [2:0]    dec_sts;
  logic          dec_mod;
  logic [DW-1:0] dec_dvd;
  logic [DW-1:0] pos_plus_size;

  assign pos_plus_size = DW'(position_i) + DW'(remove_size_i);

  always_comb begin
    dec_sts = brbe_pkg::STS_OK;
    dec_mod = 1'b0;
    dec_dvd = '0;
    case (action_i)
      brbe_pkg::ACT_PUSH: begin
        if (push_count_i > brbe_pkg::PushCntW'(brbe_pkg::PushMax)) begin
          dec_sts = brbe_pkg::STS_BAD;
        end else if (DW'(count_q) + DW'(push_count_i) > DW'(eff_cap)) begin
          dec_sts = brbe_pkg::STS_OVERFLOW;
        end else if (push_count_i != '0) begin
          dec_mod = 1'b1;
          dec_dvd = DW'(head_q) + DW'(count_q);
        end
      end
      brbe_pkg::ACT_READ: begin
        if (count_q == '0) begin
          dec_sts = brbe_pkg::STS_EMPTY;
        end else if (CW'(position_i) >= count_q) begin
          dec_sts = brbe_pkg::STS_BAD;
        end else begin
          dec_mod = 1'b1;
          dec_dvd = DW'(head_q) + DW'(position_i);
        end
      end
      brbe_pkg::ACT_REMOVE: begin
        if (CW'(position_i) >= count_q) begin
          dec_sts = brbe_pkg::STS_BAD;
        end else if (remove_size_i == '0 || remove_size_i >= count_q) begin
          dec_mod = 1'b0;
        end else if (position_i == '0) begin
          dec_mod = 1'b1;
          dec_dvd = DW'(head_q) + DW'(remove_size_i);
        end else if (pos_plus_size < DW'(count_q)) begin
          dec_mod = 1'b1;
          dec_dvd = DW'(head_q) + DW'(position_i);
        end
      end
      brbe_pkg::ACT_CLEAR: begin
        dec_mod = 1'b0;
      end
      brbe_pkg::ACT_PREFIX: begin
        if (ppos_q < count_q) begin
          dec_mod = 1'b1;
          dec_dvd = DW'(head_q) + DW'(ppos_q);
        end
      end
      default: begin
        dec_sts = brbe_pkg::STS_BAD;
      end
    endcase
  end

  logic [1:0] last_k;
  logic [1:0] byte_sel;
  assign last_k   = 2'(pcnt_q - brbe_pkg::PushCntW'(1));
  assign byte_sel = last_k - k_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      brbe_pkg::FSM_IDLE: begin
        if (in_valid_i) begin
          state_d = dec_mod ? brbe_pkg::FSM_PHYS : brbe_pkg::FSM_DONE;
        end
      end
      brbe_pkg::FSM_PHYS: begin
        if (mod_done) begin
          case (act_q)
            brbe_pkg::ACT_PUSH:   state_d = brbe_pkg::FSM_PUSH;
            brbe_pkg::ACT_REMOVE: begin
              state_d = (pos_q == '0) ? brbe_pkg::FSM_DONE : brbe_pkg::FSM_SRC;
            end
            default:              state_d = brbe_pkg::FSM_READ;
          endcase
        end
      end
      brbe_pkg::FSM_SRC: begin
        if (mod_done) begin
          state_d = brbe_pkg::FSM_MV_RD;
        end
      end
      brbe_pkg::FSM_PUSH: begin
        if (k_q == last_k) begin
          state_d = brbe_pkg::FSM_DONE;
        end
      end
      brbe_pkg::FSM_READ:  state_d = brbe_pkg::FSM_DONE;
      brbe_pkg::FSM_MV_RD: state_d = brbe_pkg::FSM_MV_WR;
      brbe_pkg::FSM_MV_WR: begin
        state_d = (left_q == CW'(1)) ? brbe_pkg::FSM_DONE : brbe_pkg::FSM_MV_RD;
      end
      brbe_pkg::FSM_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = brbe_pkg::FSM_IDLE;
        end
      end
      default: state_d = brbe_pkg::FSM_IDLE;
    endcase
  end

  // datapath, store and remainder-unit controls
  logic       pfx_done;
  logic       pfx_miss;
  logic       pfx_last;
  logic       pfx_fail;

  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    ppos_d      = ppos_q;
    pfail_d     = pfail_q;
    cap_d       = cap_q;
    out_valid_d = out_valid_q;
    act_d       = act_q;
    word_d      = word_q;
    pcnt_d      = pcnt_q;
    pos_d       = pos_q;
    size_d      = size_q;
    pval_d      = pval_q;
    plast_d     = plast_q;
    ptr_d       = ptr_q;
    src_d       = src_q;
    left_d      = left_q;
    k_d         = k_q;
    res_sts_d   = res_sts_q;
    res_byte_d  = res_byte_q;
    out_sts_d   = out_sts_q;
    out_byte_d  = out_byte_q;
    out_fill_d  = out_fill_q;
    mod_req     = '0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = ptr_q;
    mem_wdata   = mem_rdata;
    pfx_done    = 1'b0;
    pfx_miss    = 1'b0;
    pfx_last    = plast_q;

    // drop the result once the consumer takes it
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // take a capacity write whenever offered; contents, head and fill are kept
    if (cfg_valid_i) begin
      cap_d = cfg_data_i;
    end

    case (state_q)
      brbe_pkg::FSM_IDLE: begin
        if (in_valid_i) begin
          act_d      = action_i;
          word_d     = push_word_i;
          pcnt_d     = push_count_i;
          pos_d      = position_i;
          size_d     = remove_size_i;
          pval_d     = prefix_value_i;
          plast_d    = prefix_last_i;
          res_sts_d  = dec_sts;
          res_byte_d = '0;
          k_d        = '0;
          mod_req.start    = dec_mod;
          mod_req.dividend = dec_dvd;
          mod_req.divisor  = eff_cap;
          case (action_i)
            brbe_pkg::ACT_REMOVE: begin
              if (CW'(position_i) < count_q && remove_size_i != '0) begin
                if (remove_size_i >= count_q) begin
                  head_d  = '0;
                  count_d = '0;
                end else if (position_i != '0 && pos_plus_size >= DW'(count_q)) begin
                  // truncate the tail
                  count_d = CW'(position_i);
                end
              end
            end
            brbe_pkg::ACT_CLEAR: begin
              head_d  = '0;
              count_d = '0;
            end
            brbe_pkg::ACT_PREFIX: begin
              if (!dec_mod) begin
                // beyond the fill: counts as a mismatch without a store access
                pfx_done = 1'b1;
                pfx_miss = 1'b1;
                pfx_last = prefix_last_i;
              end
            end
            default: begin
              head_d = head_q;
            end
          endcase
        end
      end
      brbe_pkg::FSM_PHYS: begin
        mem_addr = mod_res;
        if (mod_done) begin
          case (act_q)
            brbe_pkg::ACT_PUSH: begin
              ptr_d = mod_res;
            end
            brbe_pkg::ACT_REMOVE: begin
              if (pos_q == '0) begin
                // advance the head past the removed front
                head_d  = mod_res;
                count_d = count_q - size_q;
              end else begin
                // destination found; now map the first byte to move down
                ptr_d            = mod_res;
                mod_req.start    = 1'b1;
                mod_req.dividend = DW'(head_q) + DW'(pos_q) + DW'(size_q);
                mod_req.divisor  = eff_cap;
              end
            end
            default: begin
              mem_re = 1'b1;
            end
          endcase
        end
      end
      brbe_pkg::FSM_SRC: begin
        if (mod_done) begin
          src_d  = mod_res;
          left_d = count_q - CW'(pos_q) - size_q;
        end
      end
      brbe_pkg::FSM_PUSH: begin
        // most significant byte of the pushed group first
        mem_we    = 1'b1;
        mem_addr  = ptr_q;
        mem_wdata = word_q[byte_sel*brbe_pkg::ByteW +: brbe_pkg::ByteW];
        ptr_d     = ring_inc(ptr_q, eff_cap);
        count_d   = count_q + CW'(1);
        k_d       = k_q + 2'd1;
      end
      brbe_pkg::FSM_READ: begin
        if (act_q == brbe_pkg::ACT_PREFIX) begin
          pfx_done = 1'b1;
          pfx_miss = (mem_rdata != pval_q);
        end else begin
          res_byte_d = mem_rdata;
        end
      end
      brbe_pkg::FSM_MV_RD: begin
        mem_re   = 1'b1;
        mem_addr = src_q;
        src_d    = ring_inc(src_q, eff_cap);
      end
      brbe_pkg::FSM_MV_WR: begin
        mem_we    = 1'b1;
        mem_addr  = ptr_q;
        mem_wdata = mem_rdata;
        ptr_d     = ring_inc(ptr_q, eff_cap);
        left_d    = left_q - CW'(1);
        if (left_q == CW'(1)) begin
          count_d = count_q - size_q;
        end
      end
      brbe_pkg::FSM_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_sts_d   = res_sts_q;
          out_byte_d  = res_byte_q;
          out_fill_d  = count_q;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase

    // prefix bookkeeping: position saturates at the maximum capacity
    pfx_fail = pfail_q | pfx_miss;
    if (pfx_done) begin
      if (pfx_last) begin
        res_sts_d = pfx_fail ? brbe_pkg::STS_NOMATCH : brbe_pkg::STS_OK;
        ppos_d    = '0;
        pfail_d   = 1'b0;
      end else begin
        res_sts_d = brbe_pkg::STS_OK;
        pfail_d   = pfx_fail;
        if (ppos_q < CW'(brbe_pkg::MaxCap)) begin
          ppos_d = ppos_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= brbe_pkg::FSM_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      ppos_q      <= '0;
      pfail_q     <= 1'b0;
      cap_q       <= CW'(brbe_pkg::MaxCap);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      ppos_q      <= ppos_d;
      pfail_q     <= pfail_d;
      cap_q       <= cap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    word_q     <= word_d;
    pcnt_q     <= pcnt_d;
    pos_q      <= pos_d;
    size_q     <= size_d;
    pval_q     <= pval_d;
    plast_q    <= plast_d;
    ptr_q      <= ptr_d;
    src_q      <= src_d;
    left_q     <= left_d;
    k_q        <= k_d;
    res_sts_q  <= res_sts_d;
    res_byte_q <= res_byte_d;
    out_sts_q  <= out_sts_d;
    out_byte_q <= out_byte_d;
    out_fill_q <= out_fill_d;
  end

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (state_q == brbe_pkg::FSM_IDLE);
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_sts_q;
  assign read_byte_o  = out_byte_q;
  assign fill_level_o = out_fill_q;

endmodule

// File: hw/rtl/brbe_chk.sv
// brbe_chk: port-level checks for byte_ring_buffer_engine, bound to the top level.
// Depends on brbe_pkg for status codes and widths.
module brbe_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [2:0]                    status_o,
  input logic [brbe_pkg::ByteW-1:0]    read_byte_o,
  input logic [brbe_pkg::CntW-1:0]     fill_level_o
);

  // hold a stalled result unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(read_byte_o) && $stable(fill_level_o))
    else $error("stalled result changed");

  // one transaction at a time: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction taken while busy");

  // a returned byte only accompanies a successful transaction
  a_byte_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_byte_o != '0 |-> status_o == brbe_pkg::STS_OK)
    else $error("read byte on failed transaction");

  // empty status always reports an empty buffer
  a_empty_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == brbe_pkg::STS_EMPTY |-> fill_level_o == '0)
    else $error("empty status with nonzero fill");

  // fill never exceeds the store size
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fill_level_o <= brbe_pkg::CntW'(brbe_pkg::MaxCap))
    else $error("fill level beyond store size");

endmodule

bind byte_ring_buffer_engine brbe_chk u_brbe_chk (.*);

// File: tb/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for byte_ring_buffer_engine, with a scoreboard class
// that predicts every status, read byte and fill level. Depends on brbe_pkg and the RTL.
module testbench;
  import brbe_pkg::*;

  // Reserved action codes: the block must answer them with a bad status.
  localparam logic [2:0] ActRsvdLo = 3'd5;
  localparam logic [2:0] ActRsvdHi = 3'd7;

  typedef struct {
    logic [2:0]          action;
    logic [WordW-1:0]    word;
    logic [PushCntW-1:0] count;
    logic [AddrW-1:0]    position;
    logic [CntW-1:0]     size;
    logic [ByteW-1:0]    pvalue;
    logic                plast;
  } ring_item_t;

  typedef struct {
    status_e          status;
    logic [ByteW-1:0] rdata;
    logic [CntW-1:0]  fill;
  } ring_result_t;

  // Scoreboard: own copy of the ring and its pointers, plus the queue of
  // results still owed by the block.
  class ring_scoreboard;
    logic [ByteW-1:0] ring_bytes [MaxCap];
    int unsigned      head_ptr   = 0;
    int unsigned      fill_cnt   = 0;
    int unsigned      pfx_pos    = 0;
    bit               pfx_failed = 1'b0;
    int unsigned      cap_reg    = MaxCap;
    ring_result_t     expected_q [$];
    int unsigned      n_fail     = 0;
    int unsigned      n_checked  = 0;

    function void set_capacity(int unsigned value);
      cap_reg = value & ((1 << CntW) - 1);
    endfunction

    function int unsigned eff_cap();
      if (cap_reg == 0) return 1;
      if (cap_reg > MaxCap) return MaxCap;
      return cap_reg;
    endfunction

    function int unsigned slot(int unsigned logical);
      return (head_ptr + logical) % eff_cap();
    endfunction

    function logic [ByteW-1:0] byte_at(int unsigned logical);
      return ring_bytes[slot(logical)];
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Apply one accepted input transaction and queue the result it owes.
    function void note_item(ring_item_t it);
      status_e          st;
      logic [ByteW-1:0] rb;
      int unsigned      n, cap, off, sz, i;
      st  = STS_OK;
      rb  = '0;
      cap = eff_cap();
      case (it.action)
        ACT_PUSH: begin
          n = it.count;
          if (n > PushMax) begin
            st = STS_BAD;
          end else if (fill_cnt + n > cap) begin
            st = STS_OVERFLOW;
          end else begin
            for (i = 0; i < n; i++) begin
              ring_bytes[slot(fill_cnt)] = ByteW'(it.word >> (ByteW * (n - 1 - i)));
              fill_cnt++;
            end
          end
        end
        ACT_READ: begin
          if (fill_cnt == 0) st = STS_EMPTY;
          else if (it.position >= fill_cnt) st = STS_BAD;
          else rb = ring_bytes[slot(it.position)];
        end
        ACT_REMOVE: begin
          off = it.position;
          sz  = it.size;
          if (off >= fill_cnt) begin
            st = STS_BAD;
          end else if (sz == 0) begin
            st = STS_OK;
          end else if (sz >= fill_cnt) begin
            head_ptr = 0;
            fill_cnt = 0;
          end else if (off == 0) begin
            head_ptr = (head_ptr + sz) % cap;
            fill_cnt -= sz;
          end else if (off + sz >= fill_cnt) begin
            fill_cnt = off;
          end else begin
            for (i = off; i + sz < fill_cnt; i++)
              ring_bytes[slot(i)] = ring_bytes[slot(i + sz)];
            fill_cnt -= sz;
          end
        end
        ACT_CLEAR: begin
          head_ptr = 0;
          fill_cnt = 0;
        end
        ACT_PREFIX: begin
          if (pfx_pos >= fill_cnt || ring_bytes[slot(pfx_pos)] != it.pvalue)
            pfx_failed = 1'b1;
          if (pfx_pos < MaxCap) pfx_pos++;
          if (it.plast) begin
            st         = pfx_failed ? STS_NOMATCH : STS_OK;
            pfx_pos    = 0;
            pfx_failed = 1'b0;
          end
        end
        default: st = STS_BAD;
      endcase
      expected_q.push_back('{st, rb, CntW'(fill_cnt)});
    endfunction

    // Compare one accepted result transaction with the oldest expectation.
    function void check_result(logic [2:0] st, logic [ByteW-1:0] rb, logic [CntW-1:0] fl);
      ring_result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result: status %0d byte %0h fill %0d", $time, st, rb, fl);
        n_fail++;
        return;
      end
      exp_r = expected_q.pop_front();
      n_checked++;
      if (st !== exp_r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_r.status, st);
        n_fail++;
      end
      if (rb !== exp_r.rdata) begin
        $display("%0t: read_byte expected %0h actual %0h", $time, exp_r.rdata, rb);
        n_fail++;
      end
      if (fl !== exp_r.fill) begin
        $display("%0t: fill_level expected %0d actual %0d", $time, exp_r.fill, fl);
        n_fail++;
      end
    endfunction
  endclass

  // Clock, reset and every block input start at a known value.
  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                cfg_valid    = 1'b0;
  logic [CntW-1:0]     cfg_data     = '0;
  logic                in_valid     = 1'b0;
  logic [2:0]          action       = ACT_CLEAR;
  logic [WordW-1:0]    push_word    = '0;
  logic [PushCntW-1:0] push_count   = '0;
  logic [AddrW-1:0]    position     = '0;
  logic [CntW-1:0]     remove_size  = '0;
  logic [ByteW-1:0]    prefix_value = '0;
  logic                prefix_last  = 1'b0;
  logic                out_ready    = 1'b0;

  logic                cfg_ready_o;
  logic                in_ready_o;
  logic                out_valid_o;
  logic [2:0]          status_o;
  logic [ByteW-1:0]    read_byte_o;
  logic [CntW-1:0]     fill_level_o;

  ring_scoreboard sb;

  // Idling knobs, in percent of cycles, and the long receiver hold-off.
  int unsigned send_idle_pct = 0;
  int unsigned rcv_stall_pct = 0;
  int unsigned hold_cycles   = 0;
  int unsigned pfx_left      = 0;
  int unsigned n_sent        = 0;
  int unsigned n_cfg         = 0;

  byte_ring_buffer_engine u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .action_i       (action),
    .push_word_i    (push_word),
    .push_count_i   (push_count),
    .position_i     (position),
    .remove_size_i  (remove_size),
    .prefix_value_i (prefix_value),
    .prefix_last_i  (prefix_last),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .status_o       (status_o),
    .read_byte_o    (read_byte_o),
    .fill_level_o   (fill_level_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Give up well past the slowest legal run.
  initial begin
    #300ms;
    $display("byte_ring_buffer_engine: mismatch");
    $finish;
  end

  // Result side: sample the pre-edge handshake, then drive the next ready.
  // A pending hold-off keeps ready low for a counted stretch of cycles.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready)
        sb.check_result(status_o, read_byte_o, fill_level_o);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  function automatic ring_item_t item_of(logic [2:0] act, logic [WordW-1:0] word,
                                         int unsigned cnt, int unsigned pos,
                                         int unsigned sz, int unsigned pval, bit last);
    ring_item_t it;
    it.action   = act;
    it.word     = word;
    it.count    = PushCntW'(cnt);
    it.position = AddrW'(pos);
    it.size     = CntW'(sz);
    it.pvalue   = ByteW'(pval);
    it.plast    = last;
    return it;
  endfunction

  // Offer one input transaction, after a random gap, and hold it until taken.
  // Valid is lowered only when a gap is inserted, so it never toggles within a step.
  task automatic send_item(ring_item_t it);
    bit lowered = 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      if (!lowered) begin
        in_valid <= 1'b0;
        lowered = 1'b1;
      end
      @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    action       <= it.action;
    push_word    <= it.word;
    push_count   <= it.count;
    position     <= it.position;
    remove_size  <= it.size;
    prefix_value <= it.pvalue;
    prefix_last  <= it.plast;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(it);
    n_sent++;
  endtask

  // Drop valid and wait for every owed result.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_capacity(int unsigned value);
    cfg_valid <= 1'b1;
    cfg_data  <= CntW'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    sb.set_capacity(value);
    n_cfg++;
  endtask

  // Next byte of a prefix check: mostly the byte the ring really holds there.
  function automatic ring_item_t prefix_byte(bit last);
    int unsigned pval;
    pval = $urandom_range(255);
    if (sb.pfx_pos < sb.fill_cnt && $urandom_range(99) < 90) pval = sb.byte_at(sb.pfx_pos);
    return item_of(ACT_PREFIX, $urandom, $urandom_range(7), $urandom, $urandom, pval, last);
  endfunction

  // Random input transaction, shaped by the predicted fill so that most
  // reads and removals land inside the contents and prefix checks mostly match.
  function automatic ring_item_t gen_item();
    ring_item_t  it;
    int unsigned f, r, sel;
    f  = sb.fill_cnt;
    it = item_of(ACT_PUSH, $urandom, $urandom_range(7), $urandom, $urandom, $urandom,
                 1'($urandom));
    if (pfx_left > 0 && $urandom_range(99) < 85) begin
      pfx_left--;
      return prefix_byte(pfx_left == 0);
    end
    r = $urandom_range(99);
    if (r < 35) begin
      it.action = ACT_PUSH;
      sel = $urandom_range(99);
      if (sel < 70) begin
        case ($urandom_range(2))
          0:       it.count = PushCntW'(1);
          1:       it.count = PushCntW'(2);
          default: it.count = PushCntW'(4);
        endcase
      end else if (sel < 85) begin
        it.count = PushCntW'(3);
      end else if (sel < 92) begin
        it.count = '0;
      end else begin
        it.count = PushCntW'($urandom_range(7, PushMax + 1));
      end
    end else if (r < 55) begin
      it.action = ACT_READ;
      if (f > 0 && $urandom_range(99) < 90) it.position = AddrW'($urandom_range(f - 1));
    end else if (r < 70) begin
      it.action = ACT_REMOVE;
      if (f > 0 && $urandom_range(99) < 85) it.position = AddrW'($urandom_range(f - 1));
      sel = $urandom_range(99);
      if (sel < 50)      it.size = CntW'($urandom_range((f / 4) + 1, 1));
      else if (sel < 65) it.size = '0;
      else if (sel < 80) it.size = CntW'(f - it.position);
      else if (sel < 90) it.size = CntW'($urandom_range((1 << CntW) - 1, f));
    end else if (r < 73) begin
      it.action = ACT_CLEAR;
    end else if (r < 95) begin
      pfx_left = $urandom_range(8, 1);
      pfx_left--;
      return prefix_byte(pfx_left == 0);
    end else if (r < 98) begin
      it.action = 3'($urandom_range(ActRsvdHi, ActRsvdLo));
    end else begin
      // stray prefix byte with a random last flag
      it.action = ACT_PREFIX;
    end
    return it;
  endfunction

  task automatic random_items(int unsigned count);
    repeat (count) send_item(gen_item());
  endtask

  // Extremes and each corner of the action set, starting from a full ring.
  task automatic directed_items();
    int unsigned i;
    send_item(item_of(ACT_PUSH, 32'h5A, 1, 0, 0, 0, 0));          // full: overflow
    send_item(item_of(ACT_PUSH, 32'h0, 0, 0, 0, 0, 0));           // zero count is ok
    send_item(item_of(ACT_READ, 32'h0, 0, 0, 0, 0, 0));
    send_item(item_of(ACT_READ, 32'h0, 0, MaxCap - 1, 0, 0, 0));
    for (i = 0; i < 3; i++)                                       // matching prefix
      send_item(item_of(ACT_PREFIX, 0, 0, 0, 0, sb.byte_at(i), i == 2));
    send_item(item_of(ACT_PREFIX, 0, 0, 0, 0, sb.byte_at(0), 0)); // mismatching prefix
    send_item(item_of(ACT_PREFIX, 0, 0, 0, 0, ~sb.byte_at(1), 1));
    send_item(item_of(ACT_PUSH, 32'hFFFF_FFFF, PushMax + 1, 0, 0, 0, 0));
    send_item(item_of(ACT_PUSH, 32'hFFFF_FFFF, 7, 0, 0, 0, 0));
    send_item(item_of(ActRsvdLo, 32'hFFFF_FFFF, 7, MaxCap - 1, 2047, 255, 1));
    send_item(item_of(ActRsvdHi, 32'h0, 0, 0, 0, 0, 0));
    send_item(item_of(ACT_REMOVE, 0, 0, 5, 0, 0, 0));             // size zero
    send_item(item_of(ACT_REMOVE, 0, 0, 0, 3, 0, 0));             // from the front
    send_item(item_of(ACT_REMOVE, 0, 0, sb.fill_cnt - 2, 5, 0, 0)); // truncate tail
    send_item(item_of(ACT_REMOVE, 0, 0, 10, 20, 0, 0));           // shift the middle
    send_item(item_of(ACT_READ, 0, 0, MaxCap - 1, 0, 0, 0));      // beyond fill
    send_item(item_of(ACT_REMOVE, 0, 0, MaxCap - 1, 1, 0, 0));    // offset beyond fill
    send_item(item_of(ACT_PUSH, 32'hFFFF_FFFF, 4, 0, 0, 0, 0));
    send_item(item_of(ACT_PUSH, 32'h00A1_B2C3, 3, 0, 0, 0, 0));
    send_item(item_of(ACT_PUSH, 32'h0, 2, 0, 0, 0, 0));
    send_item(item_of(ACT_REMOVE, 0, 0, 0, 2047, 0, 0));          // size over fill: clear
    send_item(item_of(ACT_READ, 0, 0, 0, 0, 0, 0));               // empty
    send_item(item_of(ACT_REMOVE, 0, 0, 0, 0, 0, 0));             // empty offset is bad
    send_item(item_of(ACT_PREFIX, 0, 0, 0, 0, 0, 1));             // prefix on empty
    send_item(item_of(ACT_PUSH, $urandom, 1, 0, 0, 0, 0));
    send_item(item_of(ACT_CLEAR, 0, 0, 0, 0, 0, 0));
  endtask

  // Main sequence: reset once, write every physical slot, directed corners,
  // then random phases over a range of capacities and idling patterns.
  initial begin
    sb = new;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill all slots at full capacity so no later mapping reaches an unwritten one.
    repeat (MaxCap / PushMax) send_item(item_of(ACT_PUSH, $urandom, PushMax, 0, 0, 0, 0));
    directed_items();
    random_items(150);
    drain();

    write_capacity(300);
    send_idle_pct = 56;
    random_items(150);
    drain();

    // Shrink with contents kept: pushes overflow until enough is removed.
    write_capacity(5);
    send_idle_pct = 0;
    rcv_stall_pct = 56;
    random_items(150);
    drain();

    write_capacity(1);
    send_idle_pct = 10;
    rcv_stall_pct = 10;
    random_items(120);
    drain();

    write_capacity(0);
    send_idle_pct = 0;
    rcv_stall_pct = 0;
    random_items(80);
    drain();

    // Over-range capacity; hold the receiver off so the block backs up its input.
    write_capacity((1 << CntW) - 1);
    hold_cycles = 400;
    random_items(120);
    drain();

    write_capacity(MaxCap + 1);
    rcv_stall_pct = 56;
    random_items(120);
    drain();

    write_capacity(MaxCap);
    send_idle_pct = 10;
    rcv_stall_pct = 10;
    random_items(250);
    send_idle_pct = 0;
    rcv_stall_pct = 0;
    random_items(80);

    drain();
    repeat (64) @(posedge clk_i);
    $display("Checked %0d result transactions from %0d input transactions",
             sb.n_checked, n_sent);
    $display("over %0d capacity writes, covering push, read, removal, clear, prefix and %s",
             n_cfg, "reserved codes under varied stalls.");
    if (sb.n_fail == 0 && sb.pending() == 0)
      $display("byte_ring_buffer_engine: match");
    else
      $display("byte_ring_buffer_engine: mismatch");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/brbe_pkg.sv
hw/rtl/brbe_ram.sv
hw/rtl/brbe_mod.sv
hw/rtl/byte_ring_buffer_engine.sv
hw/rtl/brbe_chk.sv
tb/testbench.sv
